[hdl/csdm_pkg.sv]
package csdm_pkg;

  // capacities of the stores
  localparam int MAX_ROWS       = 256;
  localparam int MAX_NONZEROS   = 4096;
  localparam int MAX_INNER      = 256;
  localparam int MAX_DENSE_COLS = 16;

  // field and register widths
  localparam int OPCODE_W   = 2;
  localparam int SLOT_W     = 12;
  localparam int LANE_W     = 8;
  localparam int DATUM_W    = 16;
  localparam int OUT_ROW_W  = 8;
  localparam int OUT_COL_W  = 4;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 2 * DATUM_W;
  localparam int START_W    = 13;
  localparam int ROWCNT_W   = 9;
  localparam int INNERCNT_W = 9;
  localparam int NZCNT_W    = 13;
  localparam int WIDTH_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // derived storage widths
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int NZ_AW    = $clog2(MAX_NONZEROS);
  localparam int PTR_W    = $clog2(MAX_NONZEROS + 1);
  localparam int INNER_AW = $clog2(MAX_INNER);
  localparam int DCOL_W   = $clog2(MAX_DENSE_COLS);
  localparam int DENSE_AW = INNER_AW + DCOL_W;
  localparam int DCNT_W   = $clog2(MAX_DENSE_COLS + 1);
  localparam int NZ_DW    = LANE_W + DATUM_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ROW_PTR = 2'd0,
    OP_NONZERO = 2'd1,
    OP_DENSE   = 2'd2,
    OP_COMPUTE = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NONZERO_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DENSE_WIDTH   = 2'd3;

endpackage

[hdl/csdm_ram.sv]
module csdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/csr_sparse_dense_matmul.sv]
// Sparse (CSR) times dense matrix multiply, one row of C per compute beat.
// Load beats (row pointer, nonzero, dense element) write at most one store entry each
// and leave the block idle; in_ready stays high between them. A compute beat for row i
// reads the row's start and end pointers (states S_RD0, S_RD1, S_RD2), then for each of
// the W dense columns walks the row's n nonzeros through one shared multiply-accumulate
// unit, each nonzero passing check, nonzero read, dense read, multiply and saturating
// add, plus a final check and the result beat per column. A compute beat holds the
// block until its last result is registered, paced by the single read ports of the
// nonzero and dense memories feeding the one multiplier. Results are Q.28 sums saturated
// to 40 bits, one beat per column with last on the final one; the output register lets
// new load beats be taken while the last result waits.
module csr_sparse_dense_matmul (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [csdm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [csdm_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [csdm_pkg::OPCODE_W-1:0]           opcode,
  input  logic [csdm_pkg::SLOT_W-1:0]             slot,
  input  logic [csdm_pkg::LANE_W-1:0]             lane,
  input  logic signed [csdm_pkg::DATUM_W-1:0]     datum,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [csdm_pkg::OUT_ROW_W-1:0]          out_row,
  output logic [csdm_pkg::OUT_COL_W-1:0]          out_col,
  output logic signed [csdm_pkg::ACC_W-1:0]       product_value,
  output logic                                    last
);
  import csdm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_CHK,
    S_NZ,
    S_DN,
    S_MUL,
    S_ACC,
    S_OUT
  } state_t;

  function automatic logic [PTR_W-1:0] clamp_ptr(input logic [START_W-1:0] p);
    return (32'(p) > MAX_NONZEROS) ? PTR_W'(MAX_NONZEROS) : PTR_W'(p);
  endfunction

  state_t state;

  logic [ROWCNT_W-1:0]   row_count;
  logic [INNERCNT_W-1:0] inner_count;
  logic [NZCNT_W-1:0]    nonzero_count;
  logic [WIDTH_W-1:0]    dense_width;

  logic [ROW_AW-1:0]  row;
  logic               has_next;
  logic [DCNT_W-1:0]  width_eff;
  logic [DCOL_W-1:0]  col;
  logic [PTR_W-1:0]   start_ptr;
  logic [PTR_W-1:0]   end_ptr;
  logic [PTR_W-1:0]   k;
  logic               term_ok;
  logic signed [DATUM_W-1:0] term_val;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   sum;

  logic                     accept;
  logic                     is_last;
  logic [WIDTH_W-1:0]       width_clamped;
  logic signed [ACC_W:0]    acc_wide;
  logic signed [ACC_W-1:0]  sum_next;

  logic                 rs_we;
  logic [ROW_AW-1:0]    rs_raddr;
  logic [START_W-1:0]   rs_rdata;
  logic                 nz_we;
  logic [NZ_DW-1:0]     nz_rdata;
  logic                 dn_we;
  logic [DENSE_AW-1:0]  dn_raddr;
  logic [DATUM_W-1:0]   dn_rdata;
  logic [LANE_W-1:0]    nz_col;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign rs_we = accept && (opcode == OP_ROW_PTR) && (32'(slot) < MAX_ROWS);
  assign nz_we = accept && (opcode == OP_NONZERO) && (32'(slot) < MAX_NONZEROS);
  assign dn_we = accept && (opcode == OP_DENSE) && (32'(slot) < MAX_INNER) &&
                 (32'(lane) < MAX_DENSE_COLS);

  assign rs_raddr = (state == S_RD1) ? row + ROW_AW'(1) : row;
  assign nz_col   = nz_rdata[DATUM_W +: LANE_W];
  assign dn_raddr = {nz_col[INNER_AW-1:0], col};

  csdm_ram #(.WIDTH(START_W), .DEPTH(MAX_ROWS)) u_row_start_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (slot[ROW_AW-1:0]),
    .wdata (datum[START_W-1:0]),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  csdm_ram #(.WIDTH(NZ_DW), .DEPTH(MAX_NONZEROS)) u_nonzero_ram (
    .clk   (clk),
    .we    (nz_we),
    .waddr (slot[NZ_AW-1:0]),
    .wdata ({lane, datum}),
    .raddr (k[NZ_AW-1:0]),
    .rdata (nz_rdata)
  );

  csdm_ram #(.WIDTH(DATUM_W), .DEPTH(MAX_INNER * MAX_DENSE_COLS)) u_dense_ram (
    .clk   (clk),
    .we    (dn_we),
    .waddr ({slot[INNER_AW-1:0], lane[DCOL_W-1:0]}),
    .wdata (datum),
    .raddr (dn_raddr),
    .rdata (dn_rdata)
  );

  // saturating accumulate
  always_comb begin
    acc_wide = {sum[ACC_W-1], sum} + {{(ACC_W + 1 - PROD_W){prod[PROD_W-1]}}, prod};
    if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
      sum_next = acc_wide[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      sum_next = acc_wide[ACC_W-1:0];
    end
  end

  assign width_clamped = (32'(dense_width) > MAX_DENSE_COLS) ? WIDTH_W'(MAX_DENSE_COLS)
                                                             : dense_width;
  assign is_last = (DCNT_W'(col) + DCNT_W'(1)) == width_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= ROWCNT_W'(1);
      inner_count   <= INNERCNT_W'(1);
      nonzero_count <= '0;
      dense_width   <= WIDTH_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_COUNT:     row_count     <= cfg_data[ROWCNT_W-1:0];
        REG_INNER_COUNT:   inner_count   <= cfg_data[INNERCNT_W-1:0];
        REG_NONZERO_COUNT: nonzero_count <= cfg_data[NZCNT_W-1:0];
        REG_DENSE_WIDTH:   dense_width   <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sum       <= '0;
    end else begin
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_COMPUTE)) begin
            row       <= slot[ROW_AW-1:0];
            has_next  <= (32'(slot) + 1 < 32'(row_count)) && (32'(slot) + 1 < MAX_ROWS);
            width_eff <= DCNT_W'(width_clamped);
            // bad row or zero width emits nothing
            if ((32'(slot) < 32'(row_count)) && (32'(slot) < MAX_ROWS) &&
                (width_clamped != '0)) begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          start_ptr <= clamp_ptr(rs_rdata);
          state     <= S_RD2;
        end
        S_RD2: begin
          end_ptr <= has_next ? clamp_ptr(rs_rdata) : clamp_ptr(nonzero_count);
          k       <= start_ptr;
          col     <= '0;
          sum     <= '0;
          state   <= S_CHK;
        end
        S_CHK: state <= (k < end_ptr) ? S_NZ : S_OUT;
        S_NZ:  state <= S_DN;
        S_DN: begin
          term_ok  <= ({1'b0, nz_col} < inner_count) && (32'(nz_col) < MAX_INNER);
          term_val <= nz_rdata[DATUM_W-1:0];
          state    <= S_MUL;
        end
        S_MUL: begin
          if (term_ok) begin
            prod <= term_val * $signed(dn_rdata);
          end else begin
            prod <= '0;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          sum   <= sum_next;
          k     <= k + PTR_W'(1);
          state <= S_CHK;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_row       <= OUT_ROW_W'(row);
            out_col       <= OUT_COL_W'(col);
            product_value <= sum;
            last          <= is_last;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              col   <= col + DCOL_W'(1);
              k     <= start_ptr;
              sum   <= '0;
              state <= S_CHK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_nz_read_in_row: assert property (@(posedge clk) disable iff (rst)
    state == S_NZ |-> k < end_ptr)
    else $error("nonzero read past row end");

  a_ptrs_clamped: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> (start_ptr <= PTR_W'(MAX_NONZEROS)) && (end_ptr <= PTR_W'(MAX_NONZEROS)))
    else $error("row pointer beyond nonzero store");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && out_valid && !out_ready |=> state == S_OUT)
    else $error("result dropped while output stalled");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    accept && opcode != OP_COMPUTE |=> state == S_IDLE)
    else $error("load beat left idle");
`endif

endmodule
